[src/smt_pkg.sv]
package smt_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int VALUE_W      = 32;
	localparam int COUNT_W      = 6;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_DUMP   = 2'd2;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_COUNT  = 2'd1;
	localparam logic [1:0] KIND_VALUE  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [1:0]                 operation;
		logic signed [VALUE_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]                 kind;
		logic [1:0]                 status;
		logic [COUNT_W-1:0]         entry_count;
		logic signed [VALUE_W-1:0]  item_value;
		logic                       last;
	} rsp_t;

endpackage

[src/smt_ram.sv]
module smt_ram #(
	parameter int DEPTH = smt_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH)-1:0]          waddr,
	input  logic signed [smt_pkg::VALUE_W-1:0] wdata,
	input  logic                              re,
	input  logic [$clog2(DEPTH)-1:0]          raddr,
	output logic signed [smt_pkg::VALUE_W-1:0] rdata
);

	logic signed [smt_pkg::VALUE_W-1:0] mem [DEPTH];
	logic signed [smt_pkg::VALUE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/smt_ctrl.sv]
module smt_ctrl #(
	parameter int CAPACITY = smt_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  smt_pkg::cmd_t                      cmd,
	input  logic                               can_emit,
	output logic                               emit,
	output smt_pkg::rsp_t                      emit_rsp,
	output logic                               mem_we,
	output logic [$clog2(CAPACITY)-1:0]        mem_waddr,
	output logic signed [smt_pkg::VALUE_W-1:0] mem_wdata,
	output logic                               mem_re,
	output logic [$clog2(CAPACITY)-1:0]        mem_raddr,
	input  logic signed [smt_pkg::VALUE_W-1:0] mem_rdata
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_RD    = 6'b000010,
		S_EV    = 6'b000100,
		S_PUT   = 6'b001000,
		S_DCNT  = 6'b010000,
		S_DLAST = 6'b100000
	} state_t;

	state_t                             state_q, state_d;
	logic [1:0]                         op_q, op_d;
	logic signed [smt_pkg::VALUE_W-1:0] val_q, val_d;
	logic signed [smt_pkg::VALUE_W-1:0] prev_q, prev_d;
	logic [CNT_W-1:0]                   idx_q, idx_d;
	logic [CNT_W-1:0]                   occ_q, occ_d;
	logic                               found_q, found_d;
	logic [1:0]                         status_q, status_d;
	logic [CNT_W-1:0]                   idx_m1;

	assign idx_m1    = idx_q - 1'b1;
	assign cmd_ready = (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		val_d     = val_q;
		prev_d    = prev_q;
		idx_d     = idx_q;
		occ_d     = occ_q;
		found_d   = found_q;
		status_d  = status_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = val_q;
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		emit      = 1'b0;
		emit_rsp  = '0;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					op_d  = cmd.operation;
					val_d = cmd.value;
					unique case (cmd.operation)
						smt_pkg::OP_INSERT: begin
							if (occ_q == CAP_CNT) begin
								status_d = smt_pkg::ST_FULL;
								state_d  = S_PUT;
							end else begin
								idx_d   = occ_q;
								state_d = S_RD;
							end
						end
						smt_pkg::OP_DELETE: begin
							idx_d   = '0;
							found_d = 1'b0;
							state_d = S_RD;
						end
						smt_pkg::OP_DUMP: begin
							state_d = S_DCNT;
						end
						default: begin
							// drop unknown operation
							state_d = S_IDLE;
						end
					endcase
				end
			end

			S_RD: begin
				unique case (op_q)
					smt_pkg::OP_INSERT: begin
						// walk down from the top; slot 0 reached means smallest value
						if (idx_q == '0) begin
							mem_we    = 1'b1;
							mem_waddr = '0;
							occ_d     = occ_q + 1'b1;
							status_d  = smt_pkg::ST_OK;
							state_d   = S_PUT;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = idx_m1[AW-1:0];
							state_d   = S_EV;
						end
					end
					smt_pkg::OP_DELETE: begin
						if (idx_q == occ_q) begin
							if (found_q) begin
								occ_d    = occ_q - 1'b1;
								status_d = smt_pkg::ST_OK;
							end else begin
								status_d = smt_pkg::ST_NOT_FOUND;
							end
							state_d = S_PUT;
						end else begin
							mem_re  = 1'b1;
							state_d = S_EV;
						end
					end
					default: begin
						if (idx_q == occ_q) begin
							state_d = S_DLAST;
						end else begin
							mem_re  = 1'b1;
							state_d = S_EV;
						end
					end
				endcase
			end

			S_EV: begin
				unique case (op_q)
					smt_pkg::OP_INSERT: begin
						mem_we    = 1'b1;
						mem_waddr = idx_q[AW-1:0];
						if (mem_rdata >= val_q) begin
							// shift entry up one slot
							mem_wdata = mem_rdata;
							idx_d     = idx_m1;
							state_d   = S_RD;
						end else begin
							mem_wdata = val_q;
							occ_d     = occ_q + 1'b1;
							status_d  = smt_pkg::ST_OK;
							state_d   = S_PUT;
						end
					end
					smt_pkg::OP_DELETE: begin
						if (found_q) begin
							// close the gap behind the removed entry
							mem_we    = 1'b1;
							mem_waddr = idx_m1[AW-1:0];
							mem_wdata = mem_rdata;
						end else if (mem_rdata == val_q) begin
							found_d = 1'b1;
						end
						idx_d   = idx_q + 1'b1;
						state_d = S_RD;
					end
					default: begin
						// a value is sent once the next distinct one shows up
						if (idx_q != '0 && mem_rdata != prev_q) begin
							if (can_emit) begin
								emit                = 1'b1;
								emit_rsp.kind       = smt_pkg::KIND_VALUE;
								emit_rsp.item_value = prev_q;
								prev_d              = mem_rdata;
								idx_d               = idx_q + 1'b1;
								state_d             = S_RD;
							end
						end else begin
							prev_d  = mem_rdata;
							idx_d   = idx_q + 1'b1;
							state_d = S_RD;
						end
					end
				endcase
			end

			S_DCNT: begin
				if (can_emit) begin
					emit                 = 1'b1;
					emit_rsp.kind        = smt_pkg::KIND_COUNT;
					emit_rsp.entry_count = smt_pkg::COUNT_W'(occ_q);
					emit_rsp.last        = (occ_q == '0);
					idx_d                = '0;
					state_d              = (occ_q == '0) ? S_IDLE : S_RD;
				end
			end

			S_DLAST: begin
				if (can_emit) begin
					emit                = 1'b1;
					emit_rsp.kind       = smt_pkg::KIND_VALUE;
					emit_rsp.item_value = prev_q;
					emit_rsp.last       = 1'b1;
					state_d             = S_IDLE;
				end
			end

			S_PUT: begin
				if (can_emit) begin
					emit            = 1'b1;
					emit_rsp.kind   = smt_pkg::KIND_STATUS;
					emit_rsp.status = status_q;
					emit_rsp.last   = 1'b1;
					state_d         = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		val_q    <= val_d;
		prev_q   <= prev_d;
		idx_q    <= idx_d;
		found_q  <= found_d;
		status_q <= status_d;
	end

endmodule

[src/sorted_multiset_table.sv]
// Sorted multiset table: up to CAPACITY signed 32-bit values kept in ascending
// order, duplicates allowed, stored in one single-port-read synchronous RAM.
// Command channel (cmd_valid/cmd_ready/cmd): insert, delete one occurrence, or
// dump. Result channel (rsp_valid/rsp_ready/rsp): insert and delete give one
// status beat; a dump gives the entry count, then each distinct value in
// ascending order, with last set on the final beat. Operation code 3 is dropped.
// One command is worked on at a time; cmd_ready is high only while idle.
// Every RAM access passes through a read state and an evaluate state. An insert
// walks down from the top entry, shifting each entry not below the new value up
// one slot, and goes straight to its status beat when the table is full; a delete
// walks every entry; a dump gives the count beat and then walks every entry.
// Results leave through an output register, so a new command is taken the cycle
// after the last beat is loaded, while that beat still waits.
// A stalled receiver holds the result and pauses a dump's RAM walk in place.
// Reset empties the table at once; RAM contents need no clearing.
module sorted_multiset_table #(
	parameter int CAPACITY = smt_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  smt_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output smt_pkg::rsp_t rsp
);

	localparam int AW = $clog2(CAPACITY);

	logic                               can_emit;
	logic                               emit;
	smt_pkg::rsp_t                      emit_rsp;
	logic                               mem_we;
	logic [AW-1:0]                      mem_waddr;
	logic signed [smt_pkg::VALUE_W-1:0] mem_wdata;
	logic                               mem_re;
	logic [AW-1:0]                      mem_raddr;
	logic signed [smt_pkg::VALUE_W-1:0] mem_rdata;
	logic                               rsp_valid_q;
	smt_pkg::rsp_t                      rsp_q;

	assign can_emit = !rsp_valid_q || rsp_ready;

	smt_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.can_emit  (can_emit),
		.emit      (emit),
		.emit_rsp  (emit_rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	smt_ram #(
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= emit_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[dv/smt_checker.sv]
module smt_checker #(
	parameter int CAPACITY = smt_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_ready,
	input  smt_pkg::cmd_t cmd,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  smt_pkg::rsp_t rsp,
	output int            fail_count,
	output int            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [smt_pkg::VALUE_W-1:0] shadow_vals [CAPACITY];
	int                                 shadow_cnt;
	smt_pkg::rsp_t                      expected_beats [$];

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count = fail_count + 1;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	function automatic smt_pkg::rsp_t make_beat(input logic [1:0] kind,
			input logic [1:0] status, input logic [smt_pkg::COUNT_W-1:0] count,
			input logic signed [smt_pkg::VALUE_W-1:0] val, input logic last);
		smt_pkg::rsp_t b;
		b.kind        = kind;
		b.status      = status;
		b.entry_count = count;
		b.item_value  = val;
		b.last        = last;
		return b;
	endfunction

	// Update the shadow table for one command and queue the beats it should produce.
	task automatic apply_cmd(input smt_pkg::cmd_t c);
		int pos;
		int n_distinct;
		int emitted;
		case (c.operation)
			smt_pkg::OP_INSERT: begin
				if (shadow_cnt >= CAPACITY) begin
					expected_beats.push_back(make_beat(smt_pkg::KIND_STATUS,
						smt_pkg::ST_FULL, '0, '0, 1'b1));
				end else begin
					pos = 0;
					while (pos < shadow_cnt && $signed(shadow_vals[pos]) < $signed(c.value))
						pos++;
					for (int i = shadow_cnt; i > pos; i--)
						shadow_vals[i] = shadow_vals[i-1];
					shadow_vals[pos] = c.value;
					shadow_cnt++;
					expected_beats.push_back(make_beat(smt_pkg::KIND_STATUS,
						smt_pkg::ST_OK, '0, '0, 1'b1));
				end
			end
			smt_pkg::OP_DELETE: begin
				pos = 0;
				while (pos < shadow_cnt && shadow_vals[pos] != c.value)
					pos++;
				if (pos >= shadow_cnt) begin
					expected_beats.push_back(make_beat(smt_pkg::KIND_STATUS,
						smt_pkg::ST_NOT_FOUND, '0, '0, 1'b1));
				end else begin
					for (int i = pos; i + 1 < shadow_cnt; i++)
						shadow_vals[i] = shadow_vals[i+1];
					shadow_cnt--;
					expected_beats.push_back(make_beat(smt_pkg::KIND_STATUS,
						smt_pkg::ST_OK, '0, '0, 1'b1));
				end
			end
			smt_pkg::OP_DUMP: begin
				n_distinct = 0;
				for (int i = 0; i < shadow_cnt; i++)
					if (i == 0 || shadow_vals[i] != shadow_vals[i-1])
						n_distinct++;
				expected_beats.push_back(make_beat(smt_pkg::KIND_COUNT, smt_pkg::ST_OK,
					smt_pkg::COUNT_W'(shadow_cnt), '0, shadow_cnt == 0));
				emitted = 0;
				for (int i = 0; i < shadow_cnt; i++) begin
					if (i == 0 || shadow_vals[i] != shadow_vals[i-1]) begin
						emitted++;
						expected_beats.push_back(make_beat(smt_pkg::KIND_VALUE,
							smt_pkg::ST_OK, '0, shadow_vals[i], emitted == n_distinct));
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		smt_pkg::rsp_t want;
		if (!arst_n) begin
			shadow_cnt = 0;
			expected_beats.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			// A result beat always belongs to an older command, so check it first.
			if (rsp_valid && rsp_ready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch($sformatf("unexpected beat kind %0d value 0x%0h",
						rsp.kind, rsp.item_value));
				end else begin
					want = expected_beats.pop_front();
					compare_field("kind", 32'(rsp.kind), 32'(want.kind));
					compare_field("status", 32'(rsp.status), 32'(want.status));
					compare_field("entry_count", 32'(rsp.entry_count), 32'(want.entry_count));
					compare_field("item_value", rsp.item_value, want.item_value);
					compare_field("last", 32'(rsp.last), 32'(want.last));
				end
			end
			if (cmd_valid && cmd_ready)
				apply_cmd(cmd);
			pending = expected_beats.size();
		end
	end

endmodule

[dv/tb.sv]
module tb ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         RAND_ITEMS  = 250;
	localparam int         LONG_HOLD   = 400;
	localparam int         SETTLE      = 100;
	localparam int         CYCLE_LIMIT = 600000;
	localparam logic signed [smt_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [smt_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	typedef enum int {SEG_FILL, SEG_MIXED, SEG_DRAIN} seg_t;

	logic          clk;
	logic          arst_n;
	logic          cmd_valid;
	logic          cmd_ready;
	smt_pkg::cmd_t cmd;
	logic          rsp_valid;
	logic          rsp_ready;
	smt_pkg::rsp_t rsp;
	int            fail_count;
	int            pending;

	int   cycles = 0;
	int   issued;
	bit   no_idle = 0;
	bit   hold_req = 0;
	logic signed [smt_pkg::VALUE_W-1:0] pool [16];
	logic signed [smt_pkg::VALUE_W-1:0] recent_rand [$];

	sorted_multiset_table #(.CAPACITY(smt_pkg::CAPACITY_DEF)) dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	smt_checker #(.CAPACITY(smt_pkg::CAPACITY_DEF)) chk (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_cmd(input logic [1:0] op,
			input logic signed [smt_pkg::VALUE_W-1:0] val);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= '{operation: op, value: val};
		do @(posedge clk); while (!cmd_ready);
		@(negedge clk);
		if (op != OP_UNUSED)
			issued++;
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic insert_item();
		logic signed [smt_pkg::VALUE_W-1:0] v;
		if ($urandom_range(0, 99) < 15) begin
			v = $urandom;
			recent_rand.push_back(v);
			if (recent_rand.size() > 40)
				void'(recent_rand.pop_front());
		end else begin
			v = pool[$urandom_range(0, 15)];
		end
		send_cmd(smt_pkg::OP_INSERT, v);
	endtask

	task automatic delete_item();
		logic signed [smt_pkg::VALUE_W-1:0] v;
		if (recent_rand.size() > 0 && $urandom_range(0, 9) < 3)
			v = recent_rand.pop_front();
		else
			v = pool[$urandom_range(0, 15)];
		send_cmd(smt_pkg::OP_DELETE, v);
	endtask

	task automatic run_segment(input seg_t seg);
		int r;
		case (seg)
			SEG_FILL: begin
				// Enough inserts to reach full from any starting point.
				repeat (38) insert_item();
				send_cmd(smt_pkg::OP_DUMP, $urandom);
			end
			SEG_DRAIN: begin
				repeat (25) begin
					r = $urandom_range(0, 99);
					if (r < 80)      delete_item();
					else if (r < 90) send_cmd(smt_pkg::OP_DUMP, $urandom);
					else             insert_item();
				end
			end
			default: begin
				repeat ($urandom_range(20, 30)) begin
					r = $urandom_range(0, 99);
					if (r < 50)      insert_item();
					else if (r < 78) delete_item();
					else if (r < 90) send_cmd(smt_pkg::OP_DUMP, $urandom);
					else if (r < 95) send_cmd(OP_UNUSED, $urandom);
					else             send_cmd(2'($urandom), $urandom);
				end
			end
		endcase
	endtask

	// Receiver: random back-pressure plus one long hold-off on request.
	initial begin
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				rsp_ready <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		bit paused;
		int pick;
		paused    = 0;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		issued    = 0;
		pool[0] = VAL_MIN;
		pool[1] = VAL_MAX;
		pool[2] = 0;
		pool[3] = -1;
		for (int i = 4; i < 16; i++)
			pool[i] = $urandom;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty table, extremes, duplicates, misses, unused code.
		send_cmd(smt_pkg::OP_DUMP, 0);
		send_cmd(smt_pkg::OP_DELETE, 0);
		send_cmd(smt_pkg::OP_INSERT, 0);
		send_cmd(smt_pkg::OP_INSERT, VAL_MIN);
		send_cmd(smt_pkg::OP_INSERT, VAL_MAX);
		send_cmd(smt_pkg::OP_INSERT, -1);
		send_cmd(smt_pkg::OP_INSERT, 1);
		send_cmd(smt_pkg::OP_INSERT, 0);
		send_cmd(smt_pkg::OP_INSERT, VAL_MAX);
		send_cmd(smt_pkg::OP_INSERT, VAL_MIN);
		send_cmd(smt_pkg::OP_DUMP, VAL_MAX);
		send_cmd(smt_pkg::OP_DELETE, 0);
		send_cmd(smt_pkg::OP_DELETE, 0);
		send_cmd(smt_pkg::OP_DELETE, 0);
		send_cmd(smt_pkg::OP_DELETE, VAL_MAX);
		send_cmd(OP_UNUSED, $urandom);
		send_cmd(smt_pkg::OP_DUMP, -1);
		send_cmd(smt_pkg::OP_DELETE, VAL_MIN);
		send_cmd(smt_pkg::OP_DELETE, VAL_MIN);
		send_cmd(smt_pkg::OP_DELETE, VAL_MAX);
		send_cmd(smt_pkg::OP_DELETE, -1);
		send_cmd(smt_pkg::OP_DELETE, 1);
		send_cmd(smt_pkg::OP_DUMP, 0);

		// Random: start with a fill while the receiver holds off for a long stretch.
		issued   = 0;
		hold_req = 1;
		run_segment(SEG_FILL);
		while (issued < RAND_ITEMS) begin
			if (!paused && issued >= 140) begin
				wait_drained();
				paused = 1;
			end
			if (issued >= RAND_ITEMS - 40)
				no_idle = 1;
			pick = $urandom_range(0, 5);
			if (pick == 0)      run_segment(SEG_FILL);
			else if (pick < 3)  run_segment(SEG_DRAIN);
			else                run_segment(SEG_MIXED);
		end

		cmd_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
